FILE: design/assert_macros.svh
// Assertion helpers for the checker file dwr_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while the active-low reset is asserted.
`define DWR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication built on the macro above.
`define DWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `DWR_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: design/dwr_pkg.sv
package dwr_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int DW    = 32;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_REVERSE    = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_POP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

FILE: design/dwr_if.sv
interface dwr_req_if import dwr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [2:0]           req_type;
    logic signed [DW-1:0] value;

    modport source (output valid, req_type, value, input ready);
    modport sink   (input valid, req_type, value, output ready);
endinterface

interface dwr_rsp_if import dwr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic signed [DW-1:0] popped_value;

    modport source (output valid, status, popped_value, input ready);
    modport sink   (input valid, status, popped_value, output ready);
endinterface

FILE: design/deque_with_reverse_flag.sv
// Double-ended queue of signed 32-bit values in a single-port memory of DEPTH
// words (1024 by default). Every request gives exactly one response, in the
// cycle after it is taken; a request is taken every cycle as long as the
// previous response is taken in the same cycle, since the one response
// register and the registered read port of the memory hold a single pop
// result. Reverse flips the front/back sense for all later requests. Popping
// an empty queue answers status 2, pushing into a full one drops the value
// and answers status 3; unknown request codes answer status 0. No clearing
// pass is needed after reset: only slots already pushed are ever read.
module deque_with_reverse_flag import dwr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dwr_req_if.sink   i_req,
    dwr_rsp_if.source o_rsp
);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;
    logic          r_out_valid;
    t_status       r_status, n_status;

    logic          accept;
    logic          is_push, is_pop, at_front;
    logic          full, empty;
    logic [AW-1:0] head_inc, head_dec, back_slot;
    logic [CW-1:0] back_off;
    logic [SW-1:0] back_sum;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [DW-1:0] rd_data;

    // Hold a new request while an untaken response is pending.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);

    // Back slot: next free slot for a push, last held slot for a pop.
    assign back_off  = is_push ? r_count : r_count - CW'(1);
    assign back_sum  = SW'(r_head) + SW'(back_off);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                : AW'(back_sum);

    always_comb begin
        is_push  = 1'b0;
        is_pop   = 1'b0;
        at_front = 1'b0;
        case (i_req.req_type)
            REQ_PUSH_BACK: begin
                is_push  = 1'b1;
                at_front = r_rev;
            end
            REQ_PUSH_FRONT: begin
                is_push  = 1'b1;
                at_front = !r_rev;
            end
            REQ_POP_BACK: begin
                is_pop   = 1'b1;
                at_front = r_rev;
            end
            REQ_POP_FRONT: begin
                is_pop   = 1'b1;
                at_front = !r_rev;
            end
            default: begin
                is_push  = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = ST_DONE;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = at_front ? r_head : back_slot;
        if (is_push) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                mem_we  = accept;
                n_count = r_count + CW'(1);
                if (at_front) begin
                    mem_addr = head_dec;
                    n_head   = head_dec;
                end
            end
        end else if (is_pop) begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                mem_re   = accept;
                n_status = ST_POP;
                n_count  = r_count - CW'(1);
                if (at_front) begin
                    n_head = head_inc;
                end
            end
        end else if (i_req.req_type == REQ_REVERSE) begin
            n_rev = !r_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= ST_DONE;
        end else begin
            if (accept) begin
                r_head      <= n_head;
                r_count     <= n_count;
                r_rev       <= n_rev;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    dwr_ram #(
        .WORDS (DEPTH),
        .WIDTH (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_req.value),
        .o_rdata (rd_data)
    );

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_value = (r_status == ST_POP) ? $signed(rd_data) : '0;

endmodule

FILE: design/dwr_ram.sv
module dwr_ram #(
    parameter int WORDS = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(WORDS)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/dwr_chk.sv
`include "assert_macros.svh"

module dwr_chk import dwr_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    dwr_req_if.sink   i_req,
    dwr_rsp_if.source o_rsp
);

    logic req_acc, rsp_stall;

    assign req_acc   = i_req.valid && i_req.ready;
    assign rsp_stall = o_rsp.valid && !o_rsp.ready;

    `DWR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, o_rsp.valid && $stable(o_rsp.status) && $stable(o_rsp.popped_value), "stalled response changed")
    `DWR_ASSERT_NEXT(a_rsp_follows, i_clk, i_rst_n, req_acc, o_rsp.valid, "request taken without response")
    `DWR_ASSERT_NEXT(a_rev_done, i_clk, i_rst_n, req_acc && (i_req.req_type == REQ_REVERSE), o_rsp.status == ST_DONE, "reverse must answer done")
    `DWR_ASSERT(a_zero_data, i_clk, i_rst_n, (o_rsp.valid && (o_rsp.status != ST_POP)) |-> (o_rsp.popped_value == '0), "nonzero data without pop")

endmodule

bind deque_with_reverse_flag dwr_chk u_dwr_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
